@@ sv/rbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab intersector
// Payload structs, configuration register indexes and pipeline depths.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  // Fixed-point word and limits, signed Q16.16.
  localparam int unsigned QW = 32;
  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  // Number of axes, one lane each.
  localparam int unsigned NUM_AXES = 3;

  // One quotient bit is resolved per divider stage.
  localparam int unsigned DIV_STAGES = 32;

  // Lane latency: input stage, divider, reciprocal fixup, multiply,
  // shift and saturate, min/max.
  localparam int unsigned LANE_LAT = DIV_STAGES + 5;

  // Total latency to the output register (two merge stages).
  localparam int unsigned TOTAL_LAT = LANE_LAT + 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  // Input request payload.
  typedef struct packed {
    logic signed [QW-1:0] ray_pos_x;
    logic signed [QW-1:0] ray_pos_y;
    logic signed [QW-1:0] ray_pos_z;
    logic signed [QW-1:0] ray_dir_x;
    logic signed [QW-1:0] ray_dir_y;
    logic signed [QW-1:0] ray_dir_z;
    logic signed [QW-1:0] t_best;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic                 hit;
    logic signed [QW-1:0] t_best_out;
  } out_t;

  // Slab interval produced by one lane.
  typedef struct packed {
    logic signed [QW-1:0] lo;
    logic signed [QW-1:0] hi;
  } slab_t;

endpackage

@@ sv/rbsi_lane.sv @@
// ----------------------------------------------------------------------------
// rbsi_lane: slab distances for one axis
// Pipelined reciprocal of the direction, plane distances, and ordering.
// ----------------------------------------------------------------------------
module rbsi_lane (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [rbsi_pkg::QW-1:0]        pos,
  input  logic signed [rbsi_pkg::QW-1:0]        dir,
  input  logic signed [rbsi_pkg::QW-1:0]        box_min,
  input  logic signed [rbsi_pkg::QW-1:0]        box_max,
  output rbsi_pkg::slab_t                       slab
);

  localparam int unsigned W  = rbsi_pkg::QW;
  localparam int unsigned NS = rbsi_pkg::DIV_STAGES;

  // Saturate a 33-bit difference to 32 bits.
  function automatic logic signed [W-1:0] sat33(input logic signed [W:0] v);
    logic signed [W-1:0] r;
    if (v[W] != v[W-1]) begin
      r = v[W] ? rbsi_pkg::Q_MIN : rbsi_pkg::Q_MAX;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // Floor shift by 16 of a 64-bit product, saturated to 32 bits.
  function automatic logic signed [W-1:0] shsat(input logic signed [2*W-1:0] p);
    logic signed [W-1:0] r;
    if ((p[2*W-1:W+15] != '0) && (p[2*W-1:W+15] != '1)) begin
      r = p[2*W-1] ? rbsi_pkg::Q_MIN : rbsi_pkg::Q_MAX;
    end else begin
      r = p[W+15:16];
    end
    return r;
  endfunction

  // Divider pipeline registers, one entry per stage boundary.
  logic [W-1:0]        rem_r  [NS+1];
  logic [W-1:0]        quo_r  [NS+1];
  logic [W-1:0]        dvs_r  [NS+1];
  logic                neg_r  [NS+1];
  logic                tiny_r [NS+1];
  logic signed [W-1:0] d0_r   [NS+1];
  logic signed [W-1:0] d1_r   [NS+1];

  logic [W-1:0] dabs;
  logic signed [W-1:0] rcp_nxt, rcp_r, e0_r, e1_r;
  logic signed [2*W-1:0] p0_r, p1_r;
  logic signed [W-1:0] t0_r, t1_r;
  logic signed [W-1:0] lo_r, hi_r;

  assign dabs = dir[W-1] ? (~dir + 1'b1) : dir;

  // Input stage: magnitude, sign, small-divisor flag and plane differences.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {{(W-1){1'b0}}, 1'b1};
      quo_r[0]  <= '0;
      dvs_r[0]  <= dabs;
      neg_r[0]  <= dir[W-1];
      tiny_r[0] <= (dabs <= {{(W-1){1'b0}}, 1'b1});
      d0_r[0]   <= sat33({box_min[W-1], box_min} - {pos[W-1], pos});
      d1_r[0]   <= sat33({box_max[W-1], box_max} - {pos[W-1], pos});
    end
  end

  // Restoring division of 2^32 by |d|, one quotient bit per stage.
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [W:0] sh;
    logic       ge;
    assign sh = {rem_r[k], 1'b0};
    assign ge = (sh >= {1'b0, dvs_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? W'(sh - {1'b0, dvs_r[k]}) : sh[W-1:0];
        quo_r[k+1]  <= {quo_r[k][W-2:0], ge};
        dvs_r[k+1]  <= dvs_r[k];
        neg_r[k+1]  <= neg_r[k];
        tiny_r[k+1] <= tiny_r[k];
        d0_r[k+1]   <= d0_r[k];
        d1_r[k+1]   <= d1_r[k];
      end
    end
  end

  // Reciprocal fixup: sign and saturation; divisors of magnitude 0 or 1
  // saturate, positive except for a direction of minus one.
  always_comb begin
    if (tiny_r[NS]) begin
      rcp_nxt = neg_r[NS] ? rbsi_pkg::Q_MIN : rbsi_pkg::Q_MAX;
    end else if (neg_r[NS]) begin
      rcp_nxt = ~quo_r[NS] + 1'b1;
    end else if (quo_r[NS][W-1]) begin
      rcp_nxt = rbsi_pkg::Q_MAX;
    end else begin
      rcp_nxt = quo_r[NS];
    end
  end

  // Reciprocal, multiply, shift/saturate and ordering stages.
  always_ff @(posedge clk) begin
    if (en) begin
      rcp_r <= rcp_nxt;
      e0_r  <= d0_r[NS];
      e1_r  <= d1_r[NS];
      p0_r  <= e0_r * rcp_r;
      p1_r  <= e1_r * rcp_r;
      t0_r  <= shsat(p0_r);
      t1_r  <= shsat(p1_r);
      lo_r  <= (t0_r < t1_r) ? t0_r : t1_r;
      hi_r  <= (t0_r < t1_r) ? t1_r : t0_r;
    end
  end

  assign slab.lo = lo_r;
  assign slab.hi = hi_r;

endmodule

@@ sv/rbsi_merge.sv @@
// ----------------------------------------------------------------------------
// rbsi_merge: combine the three slabs into a hit decision
// Near is the largest entry, far the smallest exit; then the best update.
// ----------------------------------------------------------------------------
module rbsi_merge (
  input  logic                           clk,
  input  logic                           en,
  input  rbsi_pkg::slab_t                slab [rbsi_pkg::NUM_AXES],
  input  logic signed [rbsi_pkg::QW-1:0] t_best,
  output rbsi_pkg::out_t                 res
);

  localparam int unsigned W = rbsi_pkg::QW;

  logic signed [W-1:0] near_nxt, far_nxt, near_r, far_r, best_r;
  rbsi_pkg::out_t res_r;

  // Interval intersection over the axes.
  always_comb begin
    near_nxt = slab[0].lo;
    far_nxt  = slab[0].hi;
    for (int a = 1; a < rbsi_pkg::NUM_AXES; a++) begin
      if (slab[a].lo > near_nxt) near_nxt = slab[a].lo;
      if (slab[a].hi < far_nxt)  far_nxt  = slab[a].hi;
    end
  end

  // Interval stage, then the result register.
  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
      best_r <= t_best;
      res_r.hit        <= (near_r < far_r) && (near_r < best_r);
      res_r.t_best_out <= ((near_r < far_r) && (near_r < best_r)) ? near_r : best_r;
    end
  end

  assign res = res_r;

endmodule

@@ sv/ray_box_slab_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect: ray against axis-aligned box, Q16.16 slab test
// Three axis lanes feed a merge stage; box corners come from configuration.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six box corner registers through cfg_we/cfg_index/cfg_data
//   while no request is in flight; indexes above five are ignored.
//   Present a ray and the current best distance on in_data with in_valid;
//   a request is taken when in_valid and in_ready are both high.
//   Each request gives exactly one result on out_data, in request order,
//   held with out_valid until out_ready is seen.
//   From acceptance to out_valid a request passes one input stage,
//   32 divider stages (one reciprocal bit per stage in each lane), then
//   fixup, multiply, saturate, min/max and two merge stages.
//   Throughput is one request per cycle unless the output stalls. The whole
//   pipeline advances in step; when the output register holds an untaken
//   result, in_ready drops and every stage holds until out_ready returns.
//   Synchronous reset clears the pipeline valid bits and sets all box
//   corners to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rbsi_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rbsi_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbsi_pkg::QW-1:0]              cfg_data
);

  localparam int unsigned W  = rbsi_pkg::QW;
  localparam int unsigned NA = rbsi_pkg::NUM_AXES;
  localparam int unsigned LL = rbsi_pkg::LANE_LAT;
  localparam int unsigned TL = rbsi_pkg::TOTAL_LAT;

  logic signed [W-1:0] box_min_r [NA];
  logic signed [W-1:0] box_max_r [NA];
  logic [TL-1:0]       vld_r;
  logic signed [W-1:0] tb_r [LL];
  logic                en;
  logic signed [W-1:0] pos  [NA];
  logic signed [W-1:0] dir  [NA];
  rbsi_pkg::slab_t     slab [NA];

  // Whole pipeline advances unless the output holds an untaken result.
  assign en        = !vld_r[TL-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[TL-1];

  // Box corner registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        box_min_r[a] <= '0;
        box_max_r[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rbsi_pkg::REG_BOX_MIN_X: box_min_r[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Y: box_min_r[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Z: box_min_r[2] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_X: box_max_r[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Y: box_max_r[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Z: box_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits follow the requests down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TL-2:0], in_valid};
    end
  end

  // Best distance travels alongside the lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      tb_r[0] <= in_data.t_best;
      for (int s = 1; s < LL; s++) tb_r[s] <= tb_r[s-1];
    end
  end

  assign pos[0] = in_data.ray_pos_x;
  assign pos[1] = in_data.ray_pos_y;
  assign pos[2] = in_data.ray_pos_z;
  assign dir[0] = in_data.ray_dir_x;
  assign dir[1] = in_data.ray_dir_y;
  assign dir[2] = in_data.ray_dir_z;

  // One lane per axis.
  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbsi_lane u_lane (
      .clk     (clk),
      .en      (en),
      .pos     (pos[a]),
      .dir     (dir[a]),
      .box_min (box_min_r[a]),
      .box_max (box_max_r[a]),
      .slab    (slab[a])
    );
  end

  // Merge the slabs and form the result.
  rbsi_merge u_merge (
    .clk    (clk),
    .en     (en),
    .slab   (slab),
    .t_best (tb_r[LL-1]),
    .res    (out_data)
  );

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled output blocks new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while output stalled");

  // An accepted request enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted request lost at pipeline entry");

endmodule

@@ dv/rbsi_checker.sv @@
// ----------------------------------------------------------------------------
// rbsi_checker: result checker for the ray/box slab intersector
// Watches the request and result channels and the configuration port, keeps
// its own copy of the box corners, predicts each result and compares it.
// ----------------------------------------------------------------------------
module rbsi_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rbsi_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rbsi_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbsi_pkg::QW-1:0]        cfg_data,
  output int                             err_count,
  output int                             pending_count
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // Prediction store; far deeper than the requests the pipeline can hold.
  localparam int unsigned PRED_DEPTH = 64;

  logic signed [rbsi_pkg::QW-1:0] corner_min_r [rbsi_pkg::NUM_AXES];
  logic signed [rbsi_pkg::QW-1:0] corner_max_r [rbsi_pkg::NUM_AXES];
  rbsi_pkg::out_t                 pred_mem [PRED_DEPTH];
  logic [5:0]                     wr_ptr_r;
  logic [5:0]                     rd_ptr_r;

  function automatic longint clamp32(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Reciprocal of a Q16.16 direction; zero saturates to the positive maximum.
  function automatic longint inv_dir(longint d);
    if (d == 0) return SAT_HI;
    return clamp32(64'sh1_0000_0000 / d);
  endfunction

  // Q16.16 product, floor rounding, saturated.
  function automatic longint scale_q(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> 16);
  endfunction

  function automatic rbsi_pkg::out_t slab_hit(rbsi_pkg::in_t r);
    longint pos [rbsi_pkg::NUM_AXES];
    longint dir [rbsi_pkg::NUM_AXES];
    longint near_t, far_t, rc, t0, t1, lo, hi;
    rbsi_pkg::out_t res;
    pos[0] = r.ray_pos_x; pos[1] = r.ray_pos_y; pos[2] = r.ray_pos_z;
    dir[0] = r.ray_dir_x; dir[1] = r.ray_dir_y; dir[2] = r.ray_dir_z;
    near_t = SAT_LO;
    far_t  = SAT_HI;
    for (int a = 0; a < rbsi_pkg::NUM_AXES; a++) begin
      rc = inv_dir(dir[a]);
      t0 = scale_q(clamp32(longint'(corner_min_r[a]) - pos[a]), rc);
      t1 = scale_q(clamp32(longint'(corner_max_r[a]) - pos[a]), rc);
      lo = (t0 < t1) ? t0 : t1;
      hi = (t0 < t1) ? t1 : t0;
      if (a == 0 || lo > near_t) near_t = lo;
      if (a == 0 || hi < far_t) far_t = hi;
    end
    res.hit = (near_t < far_t) && (near_t < longint'(r.t_best));
    res.t_best_out = res.hit ? rbsi_pkg::QW'(near_t) : r.t_best;
    return res;
  endfunction

  assign pending_count = int'(6'(wr_ptr_r - rd_ptr_r));

  // Track configuration, predict on request, compare on result.
  always @(posedge clk) begin
    rbsi_pkg::out_t want;
    if (!rst_n) begin
      for (int a = 0; a < rbsi_pkg::NUM_AXES; a++) begin
        corner_min_r[a] <= '0;
        corner_max_r[a] <= '0;
      end
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      err_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rbsi_pkg::REG_BOX_MIN_X: corner_min_r[0] <= cfg_data;
          rbsi_pkg::REG_BOX_MIN_Y: corner_min_r[1] <= cfg_data;
          rbsi_pkg::REG_BOX_MIN_Z: corner_min_r[2] <= cfg_data;
          rbsi_pkg::REG_BOX_MAX_X: corner_max_r[0] <= cfg_data;
          rbsi_pkg::REG_BOX_MAX_Y: corner_max_r[1] <= cfg_data;
          rbsi_pkg::REG_BOX_MAX_Z: corner_max_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred_mem[wr_ptr_r] <= slab_hit(in_data);
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_valid && out_ready) begin
        if (wr_ptr_r == rd_ptr_r) begin
          if (err_count < 10) $display("unexpected result %h", out_data);
          err_count <= err_count + 1;
        end else begin
          want = pred_mem[rd_ptr_r];
          rd_ptr_r <= rd_ptr_r + 1'b1;
          if (want !== out_data) begin
            if (err_count < 10)
              $display("mismatch: hit exp %b got %b, t_best_out exp %h got %h",
                       want.hit, out_data.hit, want.t_best_out, out_data.t_best_out);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ dv/tb_ray_box_slab_intersect.sv @@
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect: testbench for the ray/box slab intersector
// Directed and random rays over several box settings, with random idling on
// both channels and one long result stall; a checker predicts every result.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_LEN = 300;
  localparam int ONE = 32'h0001_0000;
  localparam logic [rbsi_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  rbsi_pkg::in_t                  in_data;
  logic                           out_valid;
  logic                           out_ready;
  rbsi_pkg::out_t                 out_data;
  logic                           cfg_we;
  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbsi_pkg::QW-1:0]        cfg_data;
  int                             err_count;
  int                             pending_count;
  int                             send_idle_pct;
  int                             recv_idle_pct;
  logic                           hold_on;
  event                           hold_start;
  int                             quiet_cycles;

  ray_box_slab_intersect dut (.*);

  rbsi_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Long receiver hold-off, counted here once started.
  initial begin
    hold_on = 1'b0;
    @(hold_start);
    hold_on = 1'b1;
    repeat (HOLD_LEN) @(negedge clk);
    hold_on = 1'b0;
  end

  // Receiver: random idling, and no ready at all during the hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_ray_box_slab_intersect: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] edge_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      5: return ONE;
      6: return -ONE;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small coordinates near the box so hits are common.
  function automatic logic [31:0] coord_word();
    case ($urandom_range(9))
      0, 1: return edge_word();
      2: return $urandom;
      default: return $urandom_range(40 * ONE) - 20 * ONE;
    endcase
  endfunction

  function automatic rbsi_pkg::in_t random_ray();
    rbsi_pkg::in_t r;
    r.ray_pos_x = coord_word(); r.ray_pos_y = coord_word(); r.ray_pos_z = coord_word();
    r.ray_dir_x = coord_word(); r.ray_dir_y = coord_word(); r.ray_dir_z = coord_word();
    r.t_best    = ($urandom_range(3) == 0) ? edge_word() : $urandom_range(30 * ONE);
    return r;
  endfunction

  // Offer one request and hold it until taken; valid drops only while idling.
  task automatic send_ray(rbsi_pkg::in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_corner(logic [rbsi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_box(logic [31:0] v [6]);
    write_corner(rbsi_pkg::REG_BOX_MIN_X, v[0]);
    write_corner(rbsi_pkg::REG_BOX_MIN_Y, v[1]);
    write_corner(rbsi_pkg::REG_BOX_MIN_Z, v[2]);
    write_corner(rbsi_pkg::REG_BOX_MAX_X, v[3]);
    write_corner(rbsi_pkg::REG_BOX_MAX_Y, v[4]);
    write_corner(rbsi_pkg::REG_BOX_MAX_Z, v[5]);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (rbsi_pkg::TOTAL_LAT + 5) @(negedge clk);
  endtask

  initial begin
    rbsi_pkg::in_t r;
    logic [31:0]   box [6];
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 31; recv_idle_pct = 81;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Unit box around the origin; directed rays first.
    box = '{-ONE, -ONE, -ONE, ONE, ONE, ONE};
    set_box(box);
    // An out-of-range index must be ignored.
    write_corner(CFG_IDX_NONE, 32'h1234_5678);
    cfg_we <= 1'b0;
    @(negedge clk);
    r = '{-4 * ONE, 0, 0, ONE, 0, 0, 32'h7FFF_FFFF};  send_ray(r);
    r = '{-4 * ONE, 0, 0, ONE, 0, 0, ONE};            send_ray(r);
    r = '{-4 * ONE, 4 * ONE, 0, ONE, 0, 0, 32'h7FFF_FFFF}; send_ray(r);
    r = '{0, 0, 0, 1, 1, 1, 32'h7FFF_FFFF};           send_ray(r);
    r = '{0, 0, 0, 32'hFFFF_FFFF, 0, 1, 32'h7FFF_FFFF}; send_ray(r);
    r = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}; send_ray(r);
    r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; send_ray(r);
    r = '{ONE, ONE, ONE, -ONE, -ONE, -ONE, 32'h7FFF_FFFF}; send_ray(r);
    r = '{4 * ONE, 0, 0, ONE, 0, 0, 32'h7FFF_FFFF};   send_ray(r);
    r = '{-4 * ONE, 0, 0, 0, 0, 0, 32'h7FFF_FFFF};    send_ray(r);
    r = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; send_ray(r);
    r = '{0, 0, 0, 0, 0, 0, 0};                       send_ray(r);
    drain();

    // Random phases over several boxes, extremes and an inverted box among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: box = '{-2 * ONE, -3 * ONE, -ONE, 5 * ONE, 2 * ONE, 4 * ONE};
        1: box = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        2: box = '{3 * ONE, 2 * ONE, 5 * ONE, -3 * ONE, -2 * ONE, -5 * ONE};
        3: box = '{0, 0, 0, 0, 0, 0};
        4: box = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        default: box = '{-8 * ONE, -8 * ONE, -8 * ONE, 8 * ONE, 8 * ONE, 8 * ONE};
      endcase
      set_box(box);
      if (phase == 2) begin
        send_idle_pct = 81; recv_idle_pct = 31;
      end else if (phase == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 265; n++) begin
        if (phase == 5 && n == 20) -> hold_start;
        send_ray(random_ray());
      end
      drain();
    end

    if (err_count == 0) begin
      $display("tb_ray_box_slab_intersect: done, clean");
    end else begin
      $display("tb_ray_box_slab_intersect: done, errors");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/rbsi_pkg.sv
sv/rbsi_lane.sv
sv/rbsi_merge.sv
sv/ray_box_slab_intersect.sv
dv/rbsi_checker.sv
dv/tb_ray_box_slab_intersect.sv
